// File: sv/stok_pkg.sv
// Package for the style sheet tokenizer: scan modes, token type codes,
// character constants and the result and queue entry types.
// Depends on nothing; every other file but stok_if imports it.
package stok_pkg;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_SEL     = 4'd1,
    M_AT      = 4'd2,
    M_PROP    = 4'd3,
    M_COLON   = 4'd4,
    M_VAL     = 4'd5,
    M_SLASH   = 4'd6,
    M_COMMENT = 4'd7,
    M_CSTAR   = 4'd8
  } mode_t;

  localparam logic [3:0] TT_SELECTOR = 4'd0;
  localparam logic [3:0] TT_COMMA    = 4'd1;
  localparam logic [3:0] TT_ATRULE   = 4'd2;
  localparam logic [3:0] TT_BSTART   = 4'd3;
  localparam logic [3:0] TT_BEND     = 4'd4;
  localparam logic [3:0] TT_PROP     = 4'd5;
  localparam logic [3:0] TT_VALUE    = 4'd6;
  localparam logic [3:0] TT_SEMI     = 4'd7;
  localparam logic [3:0] TT_UNKNOWN  = 4'd8;
  localparam logic [3:0] TT_END      = 4'd9;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // One result item.
  typedef struct packed {
    logic [7:0] token_byte;
    logic       byte_valid;
    logic       token_end;
    logic [3:0] token_type;
    logic       last_result;
  } res_t;

  // One queue entry: the one or two results caused by one input byte.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } bndl_t;

endpackage

// File: sv/stok_if.sv
// Valid/ready channel interfaces of the style sheet tokenizer.
// stok_in_if carries text bytes, stok_out_if carries result items.
// No dependencies.
interface stok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface stok_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_byte;
  logic       byte_valid;
  logic       token_end;
  logic [3:0] token_type;
  logic       last_result;

  modport source (output valid, output token_byte, output byte_valid, output token_end,
                  output token_type, output last_result, input ready);
  modport sink (input valid, input token_byte, input byte_valid, input token_end,
                input token_type, input last_result, output ready);
endinterface

// File: sv/stok_front.sv
// Front end of the tokenizer: accepts text bytes, runs the scan state
// machine and pushes the results of each byte into the queue.
// Depends on stok_pkg and stok_in_if.
module stok_front (
  input  logic            clk,
  input  logic            rst_n,
  stok_in_if.sink         in_ch,
  input  logic            push_ready,
  output logic            push_valid,
  output stok_pkg::bndl_t push_data
);
  import stok_pkg::*;

  typedef struct packed {
    mode_t      mode;
    logic       in_blk;
    logic [1:0] depth;
    logic       emit;
    res_t       res;
  } start_t;

  typedef struct packed {
    mode_t      mode;
    logic       in_blk;
    logic [1:0] depth;
    logic       any;
    bndl_t      bndl;
  } step_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c inside {CH_SPACE, [8'd9:8'd13]};
  endfunction

  function automatic logic is_sel_char(logic [7:0] c);
    return is_alpha(c) || is_digit(c) ||
           (c inside {CH_DOT, CH_HASH, CH_STAR, CH_GT, CH_COLON, CH_DASH, CH_UNDER});
  endfunction

  function automatic res_t mk(logic [7:0] b, logic v, logic e, logic [3:0] t);
    res_t r;
    r.token_byte  = b;
    r.byte_valid  = v;
    r.token_end   = e;
    r.token_type  = t;
    r.last_result = 1'b0;
    return r;
  endfunction

  function automatic logic [1:0] sat_up(logic [1:0] d);
    return (d == 2'd3) ? 2'd3 : d + 2'd1;
  endfunction

  // Handling of a byte at the start of a token.
  function automatic start_t st_start(logic [7:0] c, logic ib, logic [1:0] d);
    start_t     s;
    logic [1:0] dn;
    dn       = (d == 2'd0) ? 2'd0 : d - 2'd1;
    s.mode   = M_IDLE;
    s.in_blk = ib;
    s.depth  = d;
    s.emit   = 1'b1;
    s.res    = mk(c, 1'b1, 1'b1, TT_UNKNOWN);
    if (c == CH_NUL) begin
      s.res    = mk(CH_NUL, 1'b0, 1'b1, TT_END);
      s.in_blk = 1'b0;
      s.depth  = 2'd0;
    end else if (is_space(c)) begin
      s.emit = 1'b0;
    end else if (c == CH_SLASH) begin
      s.mode = M_SLASH;
      s.emit = 1'b0;
    end else if (ib) begin
      if (is_alpha(c)) begin
        s.mode = M_PROP;
        s.res  = mk(c, 1'b1, 1'b0, TT_PROP);
      end else if (c == CH_COLON) begin
        s.mode = M_COLON;
        s.emit = 1'b0;
      end else if (c == CH_SEMI) begin
        s.res = mk(c, 1'b1, 1'b1, TT_SEMI);
      end else if (c == CH_RBRACE) begin
        s.depth  = dn;
        s.in_blk = (dn != 2'd0);
        s.res    = mk(c, 1'b1, 1'b1, TT_BEND);
      end
    end else begin
      if (is_alpha(c) || (c inside {CH_DOT, CH_HASH, CH_STAR, CH_GT, CH_COLON})) begin
        s.mode = M_SEL;
        s.res  = mk(c, 1'b1, 1'b0, TT_SELECTOR);
      end else if (c == CH_COMMA) begin
        s.res = mk(c, 1'b1, 1'b1, TT_COMMA);
      end else if (c == CH_AT) begin
        s.mode = M_AT;
        s.emit = 1'b0;
      end else if (c == CH_LBRACE) begin
        s.depth  = sat_up(d);
        s.in_blk = 1'b1;
        s.res    = mk(c, 1'b1, 1'b1, TT_BSTART);
      end
    end
    return s;
  endfunction

  // Full handling of one byte in the current mode.
  function automatic step_t st_step(logic [7:0] c, mode_t m, logic ib, logic [1:0] d);
    step_t      o;
    start_t     s;
    logic       p_emit;
    res_t       p_res;
    logic       use_st;
    logic [1:0] d_st;
    logic       r1_emit;
    p_emit = 1'b0;
    p_res  = mk(c, 1'b1, 1'b0, TT_SELECTOR);
    use_st = 1'b0;
    d_st   = d;
    o.mode = m;
    case (m)
      M_SEL: begin
        if (is_sel_char(c)) begin
          p_emit = 1'b1;
        end else begin
          p_emit = 1'b1;
          p_res  = mk(CH_NUL, 1'b0, 1'b1, TT_SELECTOR);
          use_st = 1'b1;
        end
      end
      M_AT: begin
        p_emit = 1'b1;
        if (is_alpha(c) || c == CH_DASH) begin
          p_res = mk(c, 1'b1, 1'b0, TT_ATRULE);
        end else begin
          p_res  = mk(CH_NUL, 1'b0, 1'b1, TT_ATRULE);
          d_st   = (c == CH_LBRACE) ? sat_up(d) : d;
          use_st = 1'b1;
        end
      end
      M_PROP: begin
        p_emit = 1'b1;
        if (is_alpha(c) || c == CH_DASH) begin
          p_res = mk(c, 1'b1, 1'b0, TT_PROP);
        end else begin
          p_res  = mk(CH_NUL, 1'b0, 1'b1, (c == CH_COLON) ? TT_PROP : TT_UNKNOWN);
          use_st = 1'b1;
        end
      end
      M_COLON: begin
        if (is_space(c)) begin
          o.mode = M_COLON;
        end else if (c inside {CH_SEMI, CH_RBRACE, CH_NUL}) begin
          p_emit = 1'b1;
          p_res  = mk(CH_NUL, 1'b0, 1'b1, TT_VALUE);
          use_st = 1'b1;
        end else begin
          o.mode = M_VAL;
          p_emit = 1'b1;
          p_res  = mk(c, 1'b1, 1'b0, TT_VALUE);
        end
      end
      M_VAL: begin
        p_emit = 1'b1;
        if (is_space(c) || (c inside {CH_SEMI, CH_RBRACE, CH_NUL})) begin
          p_res  = mk(CH_NUL, 1'b0, 1'b1, TT_VALUE);
          use_st = 1'b1;
        end else begin
          p_res = mk(c, 1'b1, 1'b0, TT_VALUE);
        end
      end
      M_SLASH: begin
        if (c == CH_STAR) begin
          o.mode = M_COMMENT;
        end else begin
          p_emit = 1'b1;
          p_res  = mk(CH_SLASH, 1'b1, 1'b1, TT_UNKNOWN);
          use_st = 1'b1;
        end
      end
      M_COMMENT: begin
        if (c == CH_NUL) begin
          use_st = 1'b1;
        end else if (c == CH_STAR) begin
          o.mode = M_CSTAR;
        end
      end
      M_CSTAR: begin
        if (c == CH_NUL) begin
          use_st = 1'b1;
        end else if (c == CH_SLASH) begin
          o.mode = M_IDLE;
        end else if (c != CH_STAR) begin
          o.mode = M_COMMENT;
        end
      end
      default: begin
        use_st = 1'b1;
      end
    endcase

    s        = st_start(c, ib, d_st);
    o.in_blk = ib;
    o.depth  = d;
    if (use_st) begin
      o.mode   = s.mode;
      o.in_blk = s.in_blk;
      o.depth  = s.depth;
    end
    r1_emit    = use_st && s.emit;
    o.any      = p_emit || r1_emit;
    o.bndl.two = p_emit && r1_emit;
    o.bndl.r0  = p_emit ? p_res : s.res;
    o.bndl.r1  = s.res;
    o.bndl.r0.last_result = !(p_emit && r1_emit);
    o.bndl.r1.last_result = 1'b1;
    return o;
  endfunction

  mode_t      mode_r, mode_nxt;
  logic       in_blk_r, in_blk_nxt;
  logic [1:0] depth_r, depth_nxt;
  step_t      step_s;
  logic       take;

  assign step_s      = st_step(in_ch.text_byte, mode_r, in_blk_r, depth_r);
  assign in_ch.ready = push_ready;
  assign take        = in_ch.valid && push_ready;

  // Next state.
  always_comb begin
    mode_nxt   = mode_r;
    in_blk_nxt = in_blk_r;
    depth_nxt  = depth_r;
    if (take) begin
      mode_nxt   = step_s.mode;
      in_blk_nxt = step_s.in_blk;
      depth_nxt  = step_s.depth;
    end
  end

  // Outputs toward the queue.
  always_comb begin
    push_valid = in_ch.valid && step_s.any;
    push_data  = step_s.bndl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      in_blk_r <= 1'b0;
      depth_r  <= 2'd0;
    end else begin
      mode_r   <= mode_nxt;
      in_blk_r <= in_blk_nxt;
      depth_r  <= depth_nxt;
    end
  end

endmodule

// File: sv/stok_queue.sv
// Small FIFO of result groups between the tokenizer front and back ends.
// Depends on stok_pkg.
module stok_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  stok_pkg::bndl_t push_data,
  output logic            push_ready,
  input  logic            pop,
  output logic            pop_valid,
  output stok_pkg::bndl_t pop_data
);
  import stok_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bndl_t              mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  function automatic logic [PTR_W-1:0] wrap_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wrap_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? wrap_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: sv/stok_back.sv
// Back end of the tokenizer: takes result groups from the queue and
// delivers their one or two results on the output channel.
// Depends on stok_pkg and stok_out_if.
module stok_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  stok_pkg::bndl_t q_data,
  output logic            q_pop,
  stok_out_if.source      out_ch
);
  import stok_pkg::*;

  bndl_t cur_r, cur_nxt;
  logic  cur_v_r, cur_v_nxt;
  logic  idx_r, idx_nxt;
  logic  fire, at_last;
  res_t  sel;

  assign fire    = cur_v_r && out_ch.ready;
  assign at_last = !cur_r.two || idx_r;
  assign q_pop   = q_valid && (!cur_v_r || (fire && at_last));
  assign sel     = idx_r ? cur_r.r1 : cur_r.r0;

  always_comb begin
    cur_nxt   = cur_r;
    cur_v_nxt = cur_v_r;
    idx_nxt   = idx_r;
    if (q_pop) begin
      cur_nxt   = q_data;
      cur_v_nxt = 1'b1;
      idx_nxt   = 1'b0;
    end else if (fire) begin
      if (at_last) begin
        cur_v_nxt = 1'b0;
        idx_nxt   = 1'b0;
      end else begin
        idx_nxt = 1'b1;
      end
    end
  end

  assign out_ch.valid       = cur_v_r;
  assign out_ch.token_byte  = sel.token_byte;
  assign out_ch.byte_valid  = sel.byte_valid;
  assign out_ch.token_end   = sel.token_end;
  assign out_ch.token_type  = sel.token_type;
  assign out_ch.last_result = sel.last_result;

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      idx_r   <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// File: sv/stylesheet_tokenizer_top.sv
// Top level of the style sheet tokenizer: front end, result queue, back end.
// Depends on stok_pkg, stok_if, stok_front, stok_queue and stok_back.
//
// Channel  Role    Payload
// in_ch    sink    text_byte[7:0]
// out_ch   source  token_byte[7:0], byte_valid, token_end, token_type[3:0],
//                  last_result
//
// The front end takes one text byte per cycle while the queue has room; its
// scan state updates in the same cycle, so bytes may follow back to back.
// Each byte causes zero, one or two results; the back end delivers one result
// per cycle while out_ch is ready, so a long run of two-result bytes is paced
// by that output port. A result is first written into the queue, then popped
// into the back end's current-group register, which drives out_ch.
// Reset (rst_n low, synchronous) returns the scanner to idle outside any block
// and empties the queue; in_ch.ready drops only while the queue is full.
module stylesheet_tokenizer_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  stok_in_if.sink    in_ch,
  stok_out_if.source out_ch
);
  import stok_pkg::*;

  // Groups of results, one group per text byte that caused any result.
  logic  push_valid, push_ready;
  bndl_t push_data;
  logic  pop, pop_valid;
  bndl_t pop_data;

  // The front end classifies each byte and pushes its results.
  stok_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // The queue lets the front keep taking bytes while the output stalls.
  stok_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  // The back end hands out the results of each group in order.
  stok_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (pop_valid),
    .q_data  (pop_data),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule

// File: dv/stylesheet_tokenizer_checker.sv
`timescale 1ns / 1ps
// Checker for the style sheet tokenizer: watches both channels, predicts the tokens
// of every transferred text byte and compares them with the delivered results.
// Depends on stok_pkg and the channel interfaces in stok_if.
module stylesheet_tokenizer_checker (
  input  logic       clk,
  input  logic       rst_n,
  stok_in_if         in_ch,
  stok_out_if        out_ch,
  output int         mismatch_count,
  output int         tokens_outstanding,
  output int         results_checked
);
  import stok_pkg::*;

  // Scanner state as the block should hold it.
  mode_t      scan_state;
  logic       inside_block;
  logic [1:0] nest_depth;

  res_t step_tokens[$];
  res_t expected_tokens[$];
  int   mismatches;
  int   checked;

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void emit(input logic [7:0] b, input logic v, input logic e,
                               input logic [3:0] tt);
    res_t r;
    r.token_byte  = b;
    r.byte_valid  = v;
    r.token_end   = e;
    r.token_type  = tt;
    r.last_result = 1'b0;
    step_tokens.push_back(r);
  endfunction

  // A byte seen where a new token may begin.
  function automatic void open_token(input logic [7:0] c);
    scan_state = M_IDLE;
    if (c == CH_NUL) begin
      emit(CH_NUL, 1'b0, 1'b1, TT_END);
      inside_block = 1'b0;
      nest_depth   = 2'd0;
      return;
    end
    if (is_blank(c)) return;
    if (c == CH_SLASH) begin
      scan_state = M_SLASH;
      return;
    end
    if (inside_block) begin
      if (is_letter(c)) begin
        scan_state = M_PROP;
        emit(c, 1'b1, 1'b0, TT_PROP);
        return;
      end
      if (c == CH_COLON) begin
        scan_state = M_COLON;
        return;
      end
      if (c == CH_SEMI) begin
        emit(c, 1'b1, 1'b1, TT_SEMI);
        return;
      end
      if (c == CH_RBRACE) begin
        if (nest_depth != 2'd0) nest_depth--;
        if (nest_depth == 2'd0) inside_block = 1'b0;
        emit(c, 1'b1, 1'b1, TT_BEND);
        return;
      end
    end else begin
      if (is_letter(c) || c == CH_DOT || c == CH_HASH || c == CH_STAR || c == CH_GT ||
          c == CH_COLON) begin
        scan_state = M_SEL;
        emit(c, 1'b1, 1'b0, TT_SELECTOR);
        return;
      end
      if (c == CH_COMMA) begin
        emit(c, 1'b1, 1'b1, TT_COMMA);
        return;
      end
      if (c == CH_AT) begin
        scan_state = M_AT;
        return;
      end
      if (c == CH_LBRACE) begin
        if (nest_depth != 2'd3) nest_depth++;
        inside_block = 1'b1;
        emit(c, 1'b1, 1'b1, TT_BSTART);
        return;
      end
    end
    emit(c, 1'b1, 1'b1, TT_UNKNOWN);
  endfunction

  // Works out the tokens caused by one text byte and queues them.
  function automatic void scan_byte(input logic [7:0] c);
    res_t r;
    step_tokens.delete();
    case (scan_state)
      M_SEL: begin
        if (is_letter(c) || (c >= "0" && c <= "9") || c == CH_DOT || c == CH_HASH ||
            c == CH_STAR || c == CH_GT || c == CH_COLON || c == CH_DASH || c == CH_UNDER) begin
          emit(c, 1'b1, 1'b0, TT_SELECTOR);
        end else begin
          emit(CH_NUL, 1'b0, 1'b1, TT_SELECTOR);
          open_token(c);
        end
      end
      M_AT: begin
        if (is_letter(c) || c == CH_DASH) begin
          emit(c, 1'b1, 1'b0, TT_ATRULE);
        end else begin
          emit(CH_NUL, 1'b0, 1'b1, TT_ATRULE);
          // The brace that ends an at-rule name counts once for the rule itself.
          if (c == CH_LBRACE && nest_depth != 2'd3) nest_depth++;
          open_token(c);
        end
      end
      M_PROP: begin
        if (is_letter(c) || c == CH_DASH) begin
          emit(c, 1'b1, 1'b0, TT_PROP);
        end else begin
          emit(CH_NUL, 1'b0, 1'b1, (c == CH_COLON) ? TT_PROP : TT_UNKNOWN);
          open_token(c);
        end
      end
      M_COLON: begin
        if (is_blank(c)) begin
        end else if (c == CH_SEMI || c == CH_RBRACE || c == CH_NUL) begin
          emit(CH_NUL, 1'b0, 1'b1, TT_VALUE);
          open_token(c);
        end else begin
          scan_state = M_VAL;
          emit(c, 1'b1, 1'b0, TT_VALUE);
        end
      end
      M_VAL: begin
        if (is_blank(c) || c == CH_SEMI || c == CH_RBRACE || c == CH_NUL) begin
          emit(CH_NUL, 1'b0, 1'b1, TT_VALUE);
          open_token(c);
        end else begin
          emit(c, 1'b1, 1'b0, TT_VALUE);
        end
      end
      M_SLASH: begin
        if (c == CH_STAR) begin
          scan_state = M_COMMENT;
        end else begin
          emit(CH_SLASH, 1'b1, 1'b1, TT_UNKNOWN);
          open_token(c);
        end
      end
      M_COMMENT: begin
        if (c == CH_NUL) open_token(c);
        else if (c == CH_STAR) scan_state = M_CSTAR;
      end
      M_CSTAR: begin
        if (c == CH_NUL) open_token(c);
        else if (c == CH_SLASH) scan_state = M_IDLE;
        else if (c != CH_STAR) scan_state = M_COMMENT;
      end
      default: open_token(c);
    endcase
    foreach (step_tokens[i]) begin
      r = step_tokens[i];
      r.last_result = (i == step_tokens.size() - 1);
      expected_tokens.push_back(r);
    end
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      scan_state   = M_IDLE;
      inside_block = 1'b0;
      nest_depth   = 2'd0;
      expected_tokens.delete();
      mismatches   = 0;
      checked      = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        checked++;
        if (expected_tokens.size() == 0) begin
          $error("result with no expectation: token_byte %0d token_type %0d",
                 out_ch.token_byte, out_ch.token_type);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("token_byte", want.token_byte, out_ch.token_byte);
          check_field("byte_valid", want.byte_valid, out_ch.byte_valid);
          check_field("token_end", want.token_end, out_ch.token_end);
          check_field("token_type", want.token_type, out_ch.token_type);
          check_field("last_result", want.last_result, out_ch.last_result);
        end
      end
      if (in_ch.valid && in_ch.ready) scan_byte(in_ch.text_byte);
    end
    mismatch_count     <= mismatches;
    tokens_outstanding <= expected_tokens.size();
    results_checked    <= checked;
  end

endmodule

// File: dv/stylesheet_tokenizer_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the style sheet tokenizer: clock, reset, text stimulus and verdict.
// Depends on stok_pkg, stok_if, the block's RTL and stylesheet_tokenizer_checker.
module stylesheet_tokenizer_top_tb;
  import stok_pkg::*;

  // Cycles with no transfer on either channel before the run is declared hung.
  // Stalls are random at under half the cycles, so even a few dozen in a row
  // are practically impossible on a healthy block.
  localparam int STALL_LIMIT     = 2000;
  localparam int BYTES_PER_PHASE = 310;
  localparam int DRAIN_CYCLES    = 8;

  logic clk;
  logic rst_n;

  stok_in_if  in_ch ();
  stok_out_if out_ch ();

  int send_idle_pct;
  int recv_idle_pct;
  int bytes_sent;
  int idle_cycles;
  int mismatch_count;
  int tokens_outstanding;
  int results_checked;

  // Pending text, one byte per entry; the generators below append to it.
  logic [7:0] text_q[$];

  string letters   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  string sel_first = "abcdxyzABQZ.#*>:";
  string sel_rest  = "abcmnzAMZ0159.#*>:-_";
  string at_chars  = "abcdefghimnortuwxyzAZ-";
  string val_chars = "abcxyzAZ0123456789#%.,-()!+*/{:@";
  string blanks    = "\011\012\013\014\015 ";
  string note_text = "ab*/{};: ";

  stylesheet_tokenizer_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stylesheet_tokenizer_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_ch              (in_ch),
    .out_ch             (out_ch),
    .mismatch_count     (mismatch_count),
    .tokens_outstanding (tokens_outstanding),
    .results_checked    (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver stalls at random; the percentage changes from phase to phase.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Hang detection: count cycles in which neither channel moves a transfer.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("stylesheet_tokenizer_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] pick(input string pool);
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void add_word(input string pool, input int max_len);
    int n;
    n = $urandom_range(1, max_len);
    for (int i = 0; i < n; i++) text_q.push_back(pick(pool));
  endfunction

  // Space between tokens: usually nothing or some whitespace, now and then a
  // comment whose body holds stars and slashes to exercise the close detection.
  function automatic void add_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r >= 5 && r <= 8) begin
      add_word(blanks, r - 4);
    end else if (r == 9) begin
      text_q.push_back(CH_SLASH);
      text_q.push_back(CH_STAR);
      for (int i = $urandom_range(0, 6); i > 0; i--) text_q.push_back(pick(note_text));
      text_q.push_back(CH_STAR);
      text_q.push_back(CH_SLASH);
    end
  endfunction

  // One well-formed rule with random content: an at-rule or a selector list,
  // a block of declarations, and the closing braces.
  function automatic void add_rule();
    bit at_rule;
    bit double_close;
    int n_decl;
    int n_vals;
    at_rule      = ($urandom_range(0, 4) == 0);
    double_close = 1'b0;
    if (at_rule) begin
      text_q.push_back(CH_AT);
      add_word(at_chars, 6);
      // A brace right after the name raises the depth twice, so two closing
      // braces are needed to get back out of the block.
      if ($urandom_range(0, 1)) add_word(blanks, 1);
      else double_close = 1'b1;
    end else begin
      for (int s = $urandom_range(1, 3); s > 0; s--) begin
        text_q.push_back(pick(sel_first));
        for (int i = $urandom_range(0, 5); i > 0; i--) text_q.push_back(pick(sel_rest));
        if (s > 1) begin
          add_gap();
          text_q.push_back(CH_COMMA);
          add_gap();
        end
      end
      add_gap();
    end
    text_q.push_back(CH_LBRACE);
    n_decl = $urandom_range(0, 4);
    for (int d = 0; d < n_decl; d++) begin
      add_gap();
      text_q.push_back(pick(letters));
      for (int i = $urandom_range(0, 6); i > 0; i--) begin
        text_q.push_back(($urandom_range(0, 5) == 0) ? CH_DASH : pick(letters));
      end
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 4) == 0) add_gap();
        text_q.push_back(CH_COLON);
        add_gap();
        n_vals = $urandom_range(0, 3);
        for (int v = 0; v < n_vals; v++) begin
          if (v > 0) add_word(blanks, 2);
          add_word(val_chars, 6);
        end
      end
      // The last declaration sometimes runs straight into the closing brace.
      if (d < n_decl - 1 || $urandom_range(0, 2) != 0) begin
        add_gap();
        text_q.push_back(CH_SEMI);
      end
    end
    add_gap();
    text_q.push_back(CH_RBRACE);
    if (double_close && $urandom_range(0, 9) != 0) text_q.push_back(CH_RBRACE);
    add_gap();
  endfunction

  // Mostly well-formed rules; the rest is raw noise, rules cut short by the end
  // of text, and comments left open at the end of text.
  function automatic void add_chunk();
    int r;
    int start_len;
    int cut;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      add_rule();
    end else if (r < 85) begin
      for (int i = $urandom_range(1, 4); i > 0; i--) begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end else if (r < 95) begin
      start_len = text_q.size();
      add_rule();
      cut = $urandom_range(start_len, text_q.size() - 1);
      while (text_q.size() > cut) void'(text_q.pop_back());
      text_q.push_back(CH_NUL);
    end else begin
      text_q.push_back(CH_SLASH);
      text_q.push_back(CH_STAR);
      add_word(note_text, 4);
      text_q.push_back(CH_NUL);
    end
    if ($urandom_range(0, 9) == 0) text_q.push_back(CH_NUL);
  endfunction

  // Offers one byte, idling first at random, and returns at the edge where it
  // is transferred. Valid stays high so the next byte can follow at once.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.text_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  initial begin
    int sent_in_phase;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.text_byte = 8'h00;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 35;
    recv_idle_pct  = 46;
    bytes_sent     = 0;
    idle_cycles    = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed text. An at-rule opening its block directly (depth two), a
    // property with an empty value, a name with no colon, a value closed by a
    // brace, two braces to leave the block, a selector closed by a comma, the
    // two high byte values as stray characters, a lone slash, and a comment
    // cut off by the end of text.
    add_str("@m{p:;u;q:1}}a#>,");
    text_q.push_back(8'hFF);
    text_q.push_back(8'h80);
    add_str("/x/*");
    text_q.push_back(CH_NUL);
    while (text_q.size() != 0) send_byte(text_q.pop_front());

    // Random text in three flow-control phases: sender idles more lightly
    // than the receiver, then the reverse, then both run flat out.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 46 : 0;
      recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 35 : 0;
      sent_in_phase = 0;
      while (sent_in_phase < BYTES_PER_PHASE) begin
        if (text_q.size() == 0) add_chunk();
        send_byte(text_q.pop_front());
        sent_in_phase++;
      end
    end
    in_ch.valid <= 1'b0;

    // The outstanding count from the checker is registered, so let the last
    // byte reach it before waiting for the results to drain.
    repeat (2) @(posedge clk);
    while (tokens_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tokens_outstanding != 0) $error("%0d expected results never arrived", tokens_outstanding);
    $display("Run covered %0d text bytes and %0d checked token results", bytes_sent,
             results_checked);
    $display("over three flow-control phases, with comments, at-rules and stray bytes.");
    if (mismatch_count == 0 && tokens_outstanding == 0) begin
      $display("stylesheet_tokenizer_top verification clean");
    end else begin
      $display("stylesheet_tokenizer_top verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/stok_pkg.sv
sv/stok_if.sv
sv/stok_front.sv
sv/stok_queue.sv
sv/stok_back.sv
sv/stylesheet_tokenizer_top.sv
dv/stylesheet_tokenizer_checker.sv
dv/stylesheet_tokenizer_top_tb.sv
